FILE: src/wspc_pkg.sv
// ----------------------------------------------------------------------------
// wspc_pkg: shared types and constants for the wheel speed PID controller
// Sequencer states, operand and store selects, MAC control, saturation helpers.
// ----------------------------------------------------------------------------
package wspc_pkg;

  localparam int OPND_W = 33;          // multiplier operand width, signed
  localparam int PROD_W = 2 * OPND_W;  // registered product width
  localparam int ACC_W  = 86;          // holds deriv * kd (53b x 31b) with sign

  localparam logic [16:0] ALPHA_ONE = 17'd65536;

  // configuration register indexes
  localparam logic [2:0] CFG_KP    = 3'd0;
  localparam logic [2:0] CFG_KI    = 3'd1;
  localparam logic [2:0] CFG_KD    = 3'd2;
  localparam logic [2:0] CFG_ALPHA = 3'd3;
  localparam logic [2:0] CFG_VSCL  = 3'd4;
  localparam logic [2:0] CFG_SPER  = 3'd5;
  localparam logic [2:0] CFG_IPER  = 3'd6;
  localparam logic [2:0] CFG_PWM   = 3'd7;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RAW, ST_RAW_W, ST_RAW_S,
    ST_F1A, ST_F1B, ST_F1_W, ST_F1_S,
    ST_F2A, ST_F2B, ST_F2_W, ST_F2_S,
    ST_ERR, ST_DIF,
    ST_INT, ST_INT_W, ST_INT_S,
    ST_DER, ST_DER_W, ST_DER_S,
    ST_P, ST_P_W, ST_P_S,
    ST_I, ST_I_W, ST_I_S,
    ST_DLO, ST_DHI, ST_D_W, ST_D_S,
    ST_MAG, ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_RAW, OP_F1X, OP_F1Y, OP_F2X, OP_F2Y,
    OP_INT, OP_DER, OP_P, OP_I, OP_DLO, OP_DHI
  } op_sel_t;

  typedef enum logic [3:0] {
    SV_NONE, SV_RAW, SV_F1, SV_F2, SV_ERR, SV_DIF, SV_INT,
    SV_DER, SV_P, SV_I, SV_D, SV_MAG, SV_OUT
  } store_t;

  typedef struct packed {
    logic issue;  // load product register
    logic clr;    // product starts a fresh sum
    logic hi;     // product weighs 2^32
  } mac_ctl_t;

  typedef struct packed {
    mac_ctl_t mac;
    op_sel_t  op;
    store_t   store;
    logic     ready;
  } seq_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi_lim;
    logic signed [ACC_W-1:0] lo_lim;
    hi_lim = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
    lo_lim = {{(ACC_W-31){1'b1}}, {31{1'b0}}};
    if (v > hi_lim) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo_lim) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  // clamp to +-2^61
  function automatic logic signed [63:0] sat61(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi_lim;
    logic signed [ACC_W-1:0] lo_lim;
    hi_lim = {{(ACC_W-62){1'b0}}, 1'b1, {61{1'b0}}};
    lo_lim = {{(ACC_W-61){1'b1}}, {61{1'b0}}};
    if (v > hi_lim) begin
      return hi_lim[63:0];
    end else if (v < lo_lim) begin
      return lo_lim[63:0];
    end else begin
      return v[63:0];
    end
  endfunction

endpackage

FILE: src/wheel_speed_pid_controller_core.sv
// ----------------------------------------------------------------------------
// wheel_speed_pid_controller_core: encoder speed filter and PID, one tick per request
// The result waits in ST_OUT while the output register holds an untaken result.
// One tick at a time on the single shared 33x33 MAC; a new request waits for idle.
// Reset: clears all tick state and loads every configuration register with its default.
// ----------------------------------------------------------------------------
module wheel_speed_pid_controller_core (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] encoder_count, [63:32] target_velocity
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // [16:0] drive, [48:17] measured_velocity, zero pad
);
  import wspc_pkg::*;

  // Each dependent product goes issue -> accumulate -> store on the shared MAC;
  // the filters and the split kd product issue two back to back.

  // configuration
  logic [30:0] kp, ki, kd, vel_scale;
  logic [16:0] filter_alpha;
  logic [31:0] sample_period;
  logic [19:0] inverse_period;
  logic [15:0] drive_limit;

  // tick state
  logic signed [31:0] previous_count, first_filter, second_filter;
  logic signed [31:0] error_integral, previous_error;

  // working registers
  logic signed [31:0] delta, target, raw, err;
  logic signed [32:0] err_sum, err_dif;
  logic signed [52:0] deriv;
  logic signed [63:0] total;
  logic               mag_neg;
  logic [30:0]        mag;

  // output register
  logic signed [16:0] drive;
  logic signed [31:0] measured;

  seq_ctl_t                 ctl;
  logic signed [OPND_W-1:0] opa, opb;
  logic signed [ACC_W-1:0]  acc;
  logic                     accept;
  logic [16:0]              alpha_c;
  logic [16:0]              alpha_rest;
  logic signed [ACC_W-1:0]  err_wide;
  logic signed [ACC_W-1:0]  int_wide;
  logic signed [63:0]       total_abs;
  logic [15:0]              clamp;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = ctl.ready;
  assign m_axis_tdata  = {7'b0, measured, drive};

  // alpha above one acts as one
  assign alpha_c    = (filter_alpha > ALPHA_ONE) ? ALPHA_ONE : filter_alpha;
  assign alpha_rest = ALPHA_ONE - alpha_c;

  wspc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .out_free (!m_axis_tvalid || m_axis_tready),
    .ctl      (ctl)
  );

  wspc_mac u_mac (
    .clk (clk),
    .rst (rst),
    .ctl (ctl.mac),
    .opa (opa),
    .opb (opb),
    .acc (acc)
  );

  // operand select for the shared multiplier
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (ctl.op)
      OP_RAW: begin
        opa = OPND_W'(delta);
        opb = {2'b0, vel_scale};
      end
      OP_F1X: begin
        opa = {16'b0, alpha_c};
        opb = OPND_W'(raw);
      end
      OP_F1Y: begin
        opa = {16'b0, alpha_rest};
        opb = OPND_W'(first_filter);
      end
      OP_F2X: begin
        opa = {16'b0, alpha_c};
        opb = OPND_W'(first_filter);
      end
      OP_F2Y: begin
        opa = {16'b0, alpha_rest};
        opb = OPND_W'(second_filter);
      end
      OP_INT: begin
        opa = err_sum;
        opb = {1'b0, sample_period};
      end
      OP_DER: begin
        opa = err_dif;
        opb = {13'b0, inverse_period};
      end
      OP_P: begin
        opa = OPND_W'(err);
        opb = {2'b0, kp};
      end
      OP_I: begin
        opa = OPND_W'(error_integral);
        opb = {2'b0, ki};
      end
      OP_DLO: begin
        opa = {1'b0, deriv[31:0]};
        opb = {2'b0, kd};
      end
      OP_DHI: begin
        opa = OPND_W'($signed(deriv[52:32]));
        opb = {2'b0, kd};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // error and integral sums, widened for saturation
  assign err_wide  = ACC_W'($signed({target[31], target}) - $signed({second_filter[31],
                     second_filter}));
  // integral step is floor(sum * period / 2^33)
  assign int_wide  = ACC_W'(error_integral) + ACC_W'($signed(acc[65:33]));
  assign total_abs = total[63] ? -total : total;
  assign clamp     = ({1'b0, mag} > {16'b0, drive_limit}) ? drive_limit : mag[15:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kp             <= 31'd196608;
      ki             <= 31'd65536;
      kd             <= 31'd65536;
      filter_alpha   <= 17'd32768;
      vel_scale      <= 31'd3431;
      sample_period  <= 32'd2147484;
      inverse_period <= 20'd2000;
      drive_limit    <= 16'd255;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KP:    kp             <= cfg_data[30:0];
        CFG_KI:    ki             <= cfg_data[30:0];
        CFG_KD:    kd             <= cfg_data[30:0];
        CFG_ALPHA: filter_alpha   <= cfg_data[16:0];
        CFG_VSCL:  vel_scale      <= cfg_data[30:0];
        CFG_SPER:  sample_period  <= cfg_data;
        CFG_IPER:  inverse_period <= cfg_data[19:0];
        CFG_PWM:   drive_limit    <= cfg_data[15:0];
        default:   ;
      endcase
    end
  end

  // tick state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_count <= '0;
      first_filter   <= '0;
      second_filter  <= '0;
      error_integral <= '0;
      previous_error <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (accept) previous_count <= s_axis_tdata[31:0];
      // a new result may load in the same cycle the old one is taken
      if (ctl.store == SV_OUT) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (ctl.store)
        SV_F1:   first_filter   <= acc[47:16];  // floor divide by 2^16
        SV_F2:   second_filter  <= acc[47:16];
        SV_DIF:  previous_error <= err;
        SV_INT:  error_integral <= sat32(int_wide);
        default: ;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      delta  <= s_axis_tdata[31:0] - previous_count;  // wraps mod 2^32
      target <= s_axis_tdata[63:32];
    end
    unique case (ctl.store)
      SV_RAW: raw <= sat32(acc);
      SV_ERR: err <= sat32(err_wide);
      SV_DIF: begin
        err_sum <= OPND_W'(err) + OPND_W'(previous_error);
        err_dif <= OPND_W'(err) - OPND_W'(previous_error);
      end
      SV_DER: deriv <= acc[52:0];
      SV_P:   total <= sat61(acc);
      SV_I:   total <= total + sat61(acc);
      SV_D:   total <= total + sat61(acc);
      SV_MAG: begin
        // truncate toward zero: shift the magnitude
        mag_neg <= total[63];
        mag     <= total_abs[62:32];
      end
      SV_OUT: begin
        drive    <= mag_neg ? -$signed({1'b0, clamp}) : $signed({1'b0, clamp});
        measured <= second_filter;
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  // one request at a time: not ready right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_axis_tready)
    else $error("input accepted while a tick was in progress");

  // a result appears only from the final sequencer step
  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(ctl.store == SV_OUT))
    else $error("result valid without a completed tick");

  // drive stays within the configured range
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((!drive[16] && (drive[15:0] <= drive_limit)) ||
                       (drive[16] && ((-drive) <= $signed({1'b0, drive_limit})))))
    else $error("drive outside pwm range");

  // after loading a result the sequencer is back in idle and ready, with the result valid
  a_idle_after_out: assert property (@(posedge clk) disable iff (rst)
    (ctl.store == SV_OUT) |=> s_axis_tready && m_axis_tvalid)
    else $error("sequencer did not return to idle after loading result");
`endif

endmodule

FILE: src/wspc_mac.sv
// ----------------------------------------------------------------------------
// wspc_mac: shared multiply-accumulate unit
// Registered 33x33 signed product, accumulated in the following cycle.
// ----------------------------------------------------------------------------
module wspc_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  wspc_pkg::mac_ctl_t                    ctl,
  input  logic signed [wspc_pkg::OPND_W-1:0]    opa,
  input  logic signed [wspc_pkg::OPND_W-1:0]    opb,
  output logic signed [wspc_pkg::ACC_W-1:0]     acc
);
  import wspc_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic                     pend;
  logic                     pend_clr;
  logic                     pend_hi;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  addend;

  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign addend   = pend_hi ? {prod_ext[ACC_W-33:0], 32'b0} : prod_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= ctl.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      prod     <= opa * opb;
      pend_clr <= ctl.clr;
      pend_hi  <= ctl.hi;
    end
    if (pend) begin
      acc <= (pend_clr ? '0 : acc) + addend;
    end
  end

endmodule

FILE: src/wspc_seq.sv
// ----------------------------------------------------------------------------
// wspc_seq: control sequencer
// Steps one tick through the shared MAC: operand issue, accumulate, store.
// ----------------------------------------------------------------------------
module wspc_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,     // input request accepted
  input  logic                out_free,  // output register can take a result
  output wspc_pkg::seq_ctl_t  ctl
);
  import wspc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    ctl.mac.issue = 1'b0;
    ctl.mac.clr   = 1'b0;
    ctl.mac.hi    = 1'b0;
    ctl.op        = OP_RAW;
    ctl.store     = SV_NONE;
    ctl.ready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        ctl.ready = 1'b1;
        if (start) state_next = ST_RAW;
      end
      ST_RAW: begin
        ctl.mac   = '{issue: 1'b1, clr: 1'b1, hi: 1'b0};
        ctl.op    = OP_RAW;
        state_next = ST_RAW_W;
      end
      ST_RAW_W: state_next = ST_RAW_S;
      ST_RAW_S: begin
        ctl.store  = SV_RAW;
        state_next = ST_F1A;
      end
      ST_F1A: begin
        ctl.mac    = '{issue: 1'b1, clr: 1'b1, hi: 1'b0};
        ctl.op     = OP_F1X;
        state_next = ST_F1B;
      end
      ST_F1B: begin
        ctl.mac    = '{issue: 1'b1, clr: 1'b0, hi: 1'b0};
        ctl.op     = OP_F1Y;
        state_next = ST_F1_W;
      end
      ST_F1_W: state_next = ST_F1_S;
      ST_F1_S: begin
        ctl.store  = SV_F1;
        state_next = ST_F2A;
      end
      ST_F2A: begin
        ctl.mac    = '{issue: 1'b1, clr: 1'b1, hi: 1'b0};
        ctl.op     = OP_F2X;
        state_next = ST_F2B;
      end
      ST_F2B: begin
        ctl.mac    = '{issue: 1'b1, clr: 1'b0, hi: 1'b0};
        ctl.op     = OP_F2Y;
        state_next = ST_F2_W;
      end
      ST_F2_W: state_next = ST_F2_S;
      ST_F2_S: begin
        ctl.store  = SV_F2;
        state_next = ST_ERR;
      end
      ST_ERR: begin
        ctl.store  = SV_ERR;
        state_next = ST_DIF;
      end
      ST_DIF: begin
        ctl.store  = SV_DIF;
        state_next = ST_INT;
      end
      ST_INT: begin
        ctl.mac    = '{issue: 1'b1, clr: 1'b1, hi: 1'b0};
        ctl.op     = OP_INT;
        state_next = ST_INT_W;
      end
      ST_INT_W: state_next = ST_INT_S;
      ST_INT_S: begin
        ctl.store  = SV_INT;
        state_next = ST_DER;
      end
      ST_DER: begin
        ctl.mac    = '{issue: 1'b1, clr: 1'b1, hi: 1'b0};
        ctl.op     = OP_DER;
        state_next = ST_DER_W;
      end
      ST_DER_W: state_next = ST_DER_S;
      ST_DER_S: begin
        ctl.store  = SV_DER;
        state_next = ST_P;
      end
      ST_P: begin
        ctl.mac    = '{issue: 1'b1, clr: 1'b1, hi: 1'b0};
        ctl.op     = OP_P;
        state_next = ST_P_W;
      end
      ST_P_W: state_next = ST_P_S;
      ST_P_S: begin
        ctl.store  = SV_P;
        state_next = ST_I;
      end
      ST_I: begin
        ctl.mac    = '{issue: 1'b1, clr: 1'b1, hi: 1'b0};
        ctl.op     = OP_I;
        state_next = ST_I_W;
      end
      ST_I_W: state_next = ST_I_S;
      ST_I_S: begin
        ctl.store  = SV_I;
        state_next = ST_DLO;
      end
      ST_DLO: begin
        ctl.mac    = '{issue: 1'b1, clr: 1'b1, hi: 1'b0};
        ctl.op     = OP_DLO;
        state_next = ST_DHI;
      end
      ST_DHI: begin
        ctl.mac    = '{issue: 1'b1, clr: 1'b0, hi: 1'b1};
        ctl.op     = OP_DHI;
        state_next = ST_D_W;
      end
      ST_D_W: state_next = ST_D_S;
      ST_D_S: begin
        ctl.store  = SV_D;
        state_next = ST_MAG;
      end
      ST_MAG: begin
        ctl.store  = SV_MAG;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          ctl.store  = SV_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
